### rtl/gpio_port_pin_controller_unit_defines.svh
// Assertion macros used by the checker file of the GPIO port block.
`ifndef GPIO_PORT_PIN_CONTROLLER_UNIT_DEFINES_SVH
`define GPIO_PORT_PIN_CONTROLLER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gppc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GPPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gppc assertion failed");

`endif

### rtl/gppc_pkg.sv
// ----------------------------------------------------------------------------
// gppc_pkg
// Shared types and constants of the GPIO port pin controller.
// ----------------------------------------------------------------------------
package gppc_pkg;

  localparam int GROUP_COUNT = 2;
  localparam int PIN_COUNT   = 32;
  localparam int WORD_W      = 32;
  localparam int MEM_DEPTH   = GROUP_COUNT * PIN_COUNT;
  localparam int IDX_W       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  typedef enum logic [3:0] {
    CMD_DIRSET    = 4'd0,
    CMD_DIRGET    = 4'd1,
    CMD_OUTWRITE  = 4'd2,
    CMD_OUTTOGGLE = 4'd3,
    CMD_OUTGET    = 4'd4,
    CMD_INGET     = 4'd5,
    CMD_INENSET   = 4'd6,
    CMD_INENGET   = 4'd7,
    CMD_PULLSET   = 4'd8,
    CMD_PULLGET   = 4'd9,
    CMD_DRVSET    = 4'd10,
    CMD_DRVGET    = 4'd11,
    CMD_MUXSET    = 4'd12,
    CMD_MUXGET    = 4'd13
  } cmd_t;

  // Read-back codes and the mux select limit.
  localparam logic [3:0] PULL_OFF      = 4'd0;
  localparam logic [3:0] PULL_UP       = 4'd1;
  localparam logic [3:0] PULL_DOWN     = 4'd2;
  localparam logic [3:0] PULL_INVALID  = 4'd3;
  localparam logic [3:0] DRV_INVALID   = 4'd2;
  localparam logic [3:0] MUX_DISABLED  = 4'd8;
  localparam logic [3:0] MUX_INVALID   = 4'd9;
  localparam logic [3:0] MUX_LIMIT     = 4'd8;

  // One entry of the pin table.
  typedef struct packed {
    logic [2:0] mux_sel;
    logic       mux_en;
    logic       drv_str;
    logic       pull_en;
    logic       in_en;
  } pin_entry_t;

endpackage

### rtl/gpio_port_pin_controller_unit.sv
// ----------------------------------------------------------------------------
// gpio_port_pin_controller_unit
// Multi-group GPIO port with per-pin configuration and peripheral mux.
// ----------------------------------------------------------------------------
// The block takes one command per clock while not stalled and gives one
// result transaction for each. On acceptance the per-pin entry is read
// from a synchronous pin table with one read and one write port into the
// second stage, which modifies it, writes it back and loads the output
// register. Consecutive commands to the same pin are served by
// forwarding the entry being written, so the rate stays at one command per
// clock as long as results are taken. The direction and output-level words
// of each group live in flip-flops. The pin table needs no clearing pass
// after reset; a valid flag per entry makes unwritten entries read as zero.
module gpio_port_pin_controller_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            in_cmd,
  input  logic [2:0]            in_group_index,
  input  logic [5:0]            in_pin_index,
  input  logic [3:0]            in_set_value,
  input  logic                  in_pad_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_read_value,
  output logic                  out_bad_address,
  output logic [gppc_pkg::WORD_W-1:0] out_group_direction,
  output logic [gppc_pkg::WORD_W-1:0] out_group_output
);
  import gppc_pkg::*;

  // Group words.
  logic [WORD_W-1:0] dir_r  [GROUP_COUNT];
  logic [WORD_W-1:0] outb_r [GROUP_COUNT];

  // Pin table and its valid flags.
  pin_entry_t           mem_r [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  pin_entry_t           rd_data_r;
  logic                 rd_vld_r;

  // Second stage.
  logic        s1_v_r;
  logic [3:0]  s1_cmd_r;
  logic [GRP_W-1:0] s1_grp_r;
  logic        s1_grp_ok_r;
  logic        s1_bad_r;
  logic [4:0]  s1_pin_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [3:0]  s1_val_r;
  logic        s1_pad_r;
  logic        fwd_hit_r;
  pin_entry_t  fwd_data_r;

  // Output register.
  logic              out_valid_r;
  logic [3:0]        out_rv_r;
  logic              out_bad_r;
  logic [WORD_W-1:0] out_dir_r;
  logic [WORD_W-1:0] out_outw_r;

  logic             in_acc;
  logic             s1_adv;
  logic             s1_wr;
  logic             in_grp_ok;
  logic             in_bad;
  logic [IDX_W-1:0] in_idx;

  pin_entry_t        cur_entry;
  pin_entry_t        entry_nxt;
  logic [WORD_W-1:0] dir_w;
  logic [WORD_W-1:0] outw_w;
  logic [WORD_W-1:0] dir_nxt;
  logic [WORD_W-1:0] outw_nxt;
  logic [WORD_W-1:0] bit_m;
  logic [3:0]        rv_nxt;

  assign s1_adv   = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign s1_wr    = s1_adv && !s1_bad_r;

  assign in_grp_ok = (32'(in_group_index) < GROUP_COUNT);
  assign in_bad    = !in_grp_ok || (32'(in_pin_index) >= PIN_COUNT);
  assign in_idx    = IDX_W'(32'(in_group_index) * PIN_COUNT + 32'(in_pin_index));

  assign cur_entry = fwd_hit_r ? fwd_data_r : (rd_vld_r ? rd_data_r : '0);
  assign dir_w     = s1_grp_ok_r ? dir_r[s1_grp_r]  : '0;
  assign outw_w    = s1_grp_ok_r ? outb_r[s1_grp_r] : '0;
  assign bit_m     = WORD_W'(1) << s1_pin_r;

  always_comb begin
    entry_nxt = cur_entry;
    dir_nxt   = dir_w;
    outw_nxt  = outw_w;
    rv_nxt    = '0;
    if (s1_bad_r) begin
      unique case (s1_cmd_r)
        CMD_PULLGET: rv_nxt = PULL_INVALID;
        CMD_DRVGET:  rv_nxt = DRV_INVALID;
        CMD_MUXGET:  rv_nxt = MUX_INVALID;
        default:     rv_nxt = '0;
      endcase
    end else begin
      unique case (s1_cmd_r)
        CMD_DIRSET: begin
          if (s1_val_r == 4'd0) dir_nxt = dir_w & ~bit_m;
          else if (s1_val_r == 4'd1) dir_nxt = dir_w | bit_m;
        end
        CMD_DIRGET: rv_nxt = {3'b0, |(dir_w & bit_m)};
        CMD_OUTWRITE: begin
          if (s1_val_r == 4'd0) outw_nxt = outw_w & ~bit_m;
          else if (s1_val_r == 4'd1) outw_nxt = outw_w | bit_m;
        end
        CMD_OUTTOGGLE: outw_nxt = outw_w ^ bit_m;
        CMD_OUTGET:    rv_nxt = {3'b0, |(outw_w & bit_m)};
        CMD_INGET:     rv_nxt = {3'b0, s1_pad_r};
        CMD_INENSET:   entry_nxt.in_en = (s1_val_r != 4'd0);
        CMD_INENGET:   rv_nxt = {3'b0, cur_entry.in_en};
        CMD_PULLSET: begin
          if (s1_val_r == PULL_OFF) begin
            entry_nxt.pull_en = 1'b0;
          end else if (s1_val_r == PULL_UP || s1_val_r == PULL_DOWN) begin
            // The pull level rides on the output bit, only for inputs.
            if ((dir_w & bit_m) == '0) begin
              outw_nxt = (s1_val_r == PULL_UP) ? (outw_w | bit_m) : (outw_w & ~bit_m);
            end
            entry_nxt.pull_en = 1'b1;
          end
        end
        CMD_PULLGET: begin
          if (!cur_entry.pull_en) rv_nxt = PULL_OFF;
          else rv_nxt = ((outw_w & bit_m) != '0) ? PULL_UP : PULL_DOWN;
        end
        CMD_DRVSET: begin
          if (s1_val_r == 4'd0) entry_nxt.drv_str = 1'b0;
          else if (s1_val_r == 4'd1) entry_nxt.drv_str = 1'b1;
        end
        CMD_DRVGET: rv_nxt = {3'b0, cur_entry.drv_str};
        CMD_MUXSET: begin
          if (s1_val_r < MUX_LIMIT) begin
            entry_nxt.mux_sel = s1_val_r[2:0];
            entry_nxt.mux_en  = 1'b1;
          end else begin
            entry_nxt.mux_en = 1'b0;
          end
        end
        CMD_MUXGET: rv_nxt = cur_entry.mux_en ? {1'b0, cur_entry.mux_sel} : MUX_DISABLED;
        default: rv_nxt = '0;
      endcase
    end
  end

  // Pin table: one read and one write port, registered read data.
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem_r[s1_idx_r] <= entry_nxt;
    end
    if (in_acc) begin
      rd_data_r <= mem_r[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      s1_v_r      <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
        dir_r[g]  <= '0;
        outb_r[g] <= '0;
      end
    end else begin
      if (s1_wr) begin
        vld_r[s1_idx_r] <= 1'b1;
        dir_r[s1_grp_r]  <= dir_nxt;
        outb_r[s1_grp_r] <= outw_nxt;
      end
      if (in_acc) begin
        rd_vld_r  <= vld_r[in_idx];
        // The table read misses a write landing on the same edge.
        fwd_hit_r <= s1_wr && (s1_idx_r == in_idx);
        s1_v_r    <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_cmd;
      s1_grp_r    <= in_group_index[GRP_W-1:0];
      s1_grp_ok_r <= in_grp_ok;
      s1_bad_r    <= in_bad;
      s1_pin_r    <= in_pin_index[4:0];
      s1_idx_r    <= in_idx;
      s1_val_r    <= in_set_value;
      s1_pad_r    <= in_pad_level;
      fwd_data_r  <= entry_nxt;
    end
    if (s1_adv) begin
      out_rv_r   <= rv_nxt;
      out_bad_r  <= s1_bad_r;
      out_dir_r  <= dir_nxt;
      out_outw_r <= outw_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_value      = out_rv_r;
  assign out_bad_address     = out_bad_r;
  assign out_group_direction = out_dir_r;
  assign out_group_output    = out_outw_r;

endmodule

### rtl/gppc_checker.sv
// ----------------------------------------------------------------------------
// gppc_checker
// Port-level checks of the GPIO port pin controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "gpio_port_pin_controller_unit_defines.svh"

module gppc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [3:0]            out_read_value,
  input logic                  out_bad_address
);
  import gppc_pkg::*;

  // A held result transaction stays offered.
  `GPPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // The input side only stalls behind a full, stalled output register.
  `GPPC_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)

  // Read-back codes never exceed the invalid mux code.
  `GPPC_ASSERT_SAME(a_rv_range, out_valid, out_read_value <= MUX_INVALID)

  // A rejected address reads back only one of the fixed defaults.
  `GPPC_ASSERT_SAME(a_bad_rv, out_valid && out_bad_address, out_read_value == 4'd0 || out_read_value == PULL_INVALID || out_read_value == DRV_INVALID || out_read_value == MUX_INVALID)

endmodule

bind gpio_port_pin_controller_unit gppc_checker u_gppc_checker (.*);
